/* rtl/usfb_pkg.sv */
// Package of the URL slug byte filter: item kinds, character constants, queue entry type.
package usfb_pkg;

    // Kind of a queued item, set by the front classifier
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_TERM  = 2'd0;
    localparam t_kind KIND_SEP   = 2'd1;
    localparam t_kind KIND_ALNUM = 2'd2;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CASE_OFFSET = CH_LOWER_A - CH_UPPER_A;

    // Capacity register reset value
    localparam logic [15:0] CAPACITY_RESET = 16'd256;

    // Queue entry: classified item with its lowered byte
    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_val;
    } t_item;

endpackage

/* rtl/usfb_front.sv */
// Front of the slug filter: accepts input items and classifies them for the queue.
module usfb_front (
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char_byte,
    input  logic           i_queue_not_full,
    output logic           o_push,
    output usfb_pkg::t_item o_item
);
    import usfb_pkg::*;

    logic is_upper;
    logic is_alnum;

    // Accept whenever the queue has a free slot
    assign o_ready = i_queue_not_full;
    assign o_push  = i_valid && i_queue_not_full;

    // Classify the byte and lower ASCII capitals
    always_comb begin
        is_upper = i_char_byte inside {[CH_UPPER_A:CH_UPPER_Z]};
        is_alnum = i_char_byte inside {[CH_DIGIT_0:CH_DIGIT_9], [CH_LOWER_A:CH_LOWER_Z],
                                       [CH_UPPER_A:CH_UPPER_Z]};
        o_item.char_val = is_upper ? (i_char_byte + CASE_OFFSET) : i_char_byte;
        if (i_char_byte == CH_NUL) begin
            o_item.kind = KIND_TERM;
        end else if (is_alnum) begin
            o_item.kind = KIND_ALNUM;
        end else begin
            o_item.kind = KIND_SEP;
        end
    end

endmodule

/* rtl/usfb_queue.sv */
// Short FIFO of classified items between the front and the back of the slug filter.
module usfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  usfb_pkg::t_item i_item,
    output logic            o_not_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output usfb_pkg::t_item o_head
);
    import usfb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_not_full   = (r_count != FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Advance pointers and track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_not_full |-> !i_push)
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_head_valid |-> !i_pop)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");
`endif

endmodule

/* rtl/usfb_back.sv */
// Back of the slug filter: string state, capacity checks and the output register.
module usfb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_head_valid,
    input  usfb_pkg::t_item i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic [15:0]     o_out_position,
    output logic            o_string_done,
    output logic            o_overflow_error
);
    import usfb_pkg::*;

    logic [15:0] r_capacity;
    logic        r_have_content, n_have_content;
    logic        r_pending_dash, n_pending_dash;
    logic [15:0] r_written, n_written;
    logic        r_overflowed, n_overflowed;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_byte, n_byte;
    logic [15:0] r_pos, n_pos;
    logic        r_done, n_done;
    logic        r_err, n_err;

    logic        can_load;
    logic        no_room;
    logic        load_term;

    assign can_load = !r_out_valid || i_ready;
    assign no_room  = ({1'b0, r_written} + 17'd1) >= {1'b0, r_capacity};

    // Execute the head item against the string state
    always_comb begin
        n_have_content = r_have_content;
        n_pending_dash = r_pending_dash;
        n_written      = r_written;
        n_overflowed   = r_overflowed;
        n_out_valid    = r_out_valid && !i_ready;
        n_byte         = r_byte;
        n_pos          = r_pos;
        n_done         = r_done;
        n_err          = r_err;
        o_pop          = 1'b0;
        load_term      = 1'b0;
        if (i_head_valid) begin
            case (i_head.kind)
                KIND_TERM: begin
                    if (can_load) begin
                        o_pop          = 1'b1;
                        load_term      = 1'b1;
                        n_out_valid    = 1'b1;
                        n_byte         = CH_NUL;
                        n_pos          = r_written;
                        n_done         = 1'b1;
                        n_err          = r_overflowed || (r_written >= r_capacity);
                        n_have_content = 1'b0;
                        n_pending_dash = 1'b0;
                        n_written      = '0;
                        n_overflowed   = 1'b0;
                    end
                end
                KIND_SEP: begin
                    o_pop = 1'b1;
                    if (r_have_content) begin
                        n_pending_dash = 1'b1;
                    end
                end
                KIND_ALNUM: begin
                    if (r_overflowed) begin
                        o_pop = 1'b1;
                    end else if (can_load) begin
                        if (no_room) begin
                            // Drop the byte and latch the error
                            o_pop        = 1'b1;
                            n_overflowed = 1'b1;
                        end else if (r_have_content && r_pending_dash) begin
                            // Emit the dash first; hold the item for its byte
                            n_out_valid    = 1'b1;
                            n_byte         = CH_DASH;
                            n_pos          = r_written;
                            n_done         = 1'b0;
                            n_err          = 1'b0;
                            n_written      = r_written + 16'd1;
                            n_pending_dash = 1'b0;
                        end else begin
                            o_pop          = 1'b1;
                            n_out_valid    = 1'b1;
                            n_byte         = i_head.char_val;
                            n_pos          = r_written;
                            n_done         = 1'b0;
                            n_err          = 1'b0;
                            n_written      = r_written + 16'd1;
                            n_have_content = 1'b1;
                            n_pending_dash = 1'b0;
                        end
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity     <= CAPACITY_RESET;
            r_have_content <= 1'b0;
            r_pending_dash <= 1'b0;
            r_written      <= '0;
            r_overflowed   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_have_content <= n_have_content;
            r_pending_dash <= n_pending_dash;
            r_written      <= n_written;
            r_overflowed   <= n_overflowed;
            r_out_valid    <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_pos  <= n_pos;
        r_done <= n_done;
        r_err  <= n_err;
    end

    assign o_valid          = r_out_valid;
    assign o_out_byte       = r_byte;
    assign o_out_position   = r_pos;
    assign o_string_done    = r_done;
    assign o_overflow_error = r_err;

`ifndef SYNTH
    a_done_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> (r_byte == CH_NUL))
        else $error("terminator result with nonzero byte");
    a_err_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_done) |-> !r_err)
        else $error("error flag on a non-terminator result");
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_term |=> (r_written == '0 && !r_overflowed && !r_have_content))
        else $error("string state not cleared after terminator");
`endif

endmodule

/* rtl/url_slug_byte_filter_core.sv */
// Top level of the URL slug byte filter: front classifier, item queue, back executor.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_char_byte
//  result    out        o_valid / i_ready    o_out_byte, o_out_position,
//                                            o_string_done, o_overflow_error
//  config    in         i_cfg_we             i_cfg_data (capacity in bytes)
//
//  One item is accepted per cycle while the queue has room; a result passes through
//  the queue entry and then the output register.
//  An alphanumeric item that needs a dash before it holds the queue head while the
//  dash is loaded and leaves with its own byte; other items leave when executed.
//  Reset is synchronous, active low, and sets the capacity to 256 and clears the
//  string state and the queue. A stalled output holds a byte or terminator at the
//  queue head; the front keeps accepting until QUEUE_DEPTH items wait.
module url_slug_byte_filter_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_out_position,
    output logic        o_string_done,
    output logic        o_overflow_error
);
    import usfb_pkg::*;

    logic  push;
    t_item push_item;
    logic  queue_not_full;
    logic  pop;
    logic  head_valid;
    t_item head;

    // Classify and accept items
    usfb_front u_front (
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_char_byte      (i_char_byte),
        .i_queue_not_full (queue_not_full),
        .o_push           (push),
        .o_item           (push_item)
    );

    // Hold classified items between front and back
    usfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_not_full   (queue_not_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Execute items and drive results
    usfb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_out_position   (o_out_position),
        .o_string_done    (o_string_done),
        .o_overflow_error (o_overflow_error)
    );

endmodule
